// ----- design/brs_pkg.sv -----
// Shared types and constants for the bilinear RGB sampler.
`timescale 1ns / 1ps

package brs_pkg;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA_RED    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA_GREEN  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODATA_BLUE   = 3'd5;

   localparam logic [9:0] SIZE_RESET  = 10'd512;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

   typedef struct packed {
      logic              op;
      logic [8:0]        write_col;
      logic [8:0]        write_row;
      logic [7:0]        write_red;
      logic [7:0]        write_green;
      logic [7:0]        write_blue;
      logic signed [23:0] sample_x;
      logic signed [23:0] sample_y;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Per-sample control carried alongside the memory read.
   typedef struct packed {
      logic       in_image;
      logic       x_odd;
      logic       y_odd;
      logic [7:0] fx;
      logic [7:0] fy;
   } smp_type;

   typedef struct packed {
      logic       enable;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } nodata_type;

endpackage

// ----- design/brs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module brs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/brs_addr.sv -----
// Coordinate clamp and four-bank address generation for writes and samples.
`timescale 1ns / 1ps

module brs_addr #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic               item_valid,
   input  brs_pkg::req_type   req,
   input  logic [9:0]         image_width,
   input  logic [9:0]         image_height,
   output logic [3:0]         wr_en,
   output logic [((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2) > 1 ?
                 $clog2(((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2)) - 1 : 0 : 0] wr_addr,
   output logic [3:0][((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2) > 1 ?
                 $clog2(((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2)) - 1 : 0 : 0] rd_addr,
   output brs_pkg::smp_type   smp
);

   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int XSW        = XW + 1;
   localparam int YSW        = YW + 1;
   localparam int XCW        = (XSW > 10) ? XSW : 10;
   localparam int YCW        = (YSW > 10) ? YSW : 10;
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [XCW-1:0]     w_ext;
   logic [YCW-1:0]     h_ext;
   logic [XSW-1:0]     w_sat, w_m1, w_m2;
   logic [YSW-1:0]     h_sat, h_m1, h_m2;
   logic signed [24:0] sx, sy, top_x, top_y, lim_x, lim_y, cx, cy;
   logic [XW-1:0]      x0, x_half, x_half_even;
   logic [YW-1:0]      y0, y_half, y_half_even;
   logic [XW-1:0]      wx;
   logic [YW-1:0]      wy;
   logic               in_store;
   logic [AW-1:0]      row_base [2];
   logic [AW-1:0]      col_off [2];

   always_comb begin
      // sizes saturated to [2, MAX]
      w_ext = XCW'(image_width);
      h_ext = YCW'(image_height);
      if (w_ext < XCW'(2)) begin
         w_sat = XSW'(2);
      end else if (w_ext > XCW'(MAX_WIDTH)) begin
         w_sat = XSW'(MAX_WIDTH);
      end else begin
         w_sat = XSW'(w_ext);
      end
      if (h_ext < YCW'(2)) begin
         h_sat = YSW'(2);
      end else if (h_ext > YCW'(MAX_HEIGHT)) begin
         h_sat = YSW'(MAX_HEIGHT);
      end else begin
         h_sat = YSW'(h_ext);
      end
      w_m1 = w_sat - XSW'(1);
      w_m2 = w_sat - XSW'(2);
      h_m1 = h_sat - YSW'(1);
      h_m2 = h_sat - YSW'(2);

      sx    = {req.sample_x[23], req.sample_x};
      sy    = {req.sample_y[23], req.sample_y};
      top_x = 25'({w_m2, 8'h00});
      top_y = 25'({h_m2, 8'h00});
      lim_x = 25'({w_m1, 8'h00});
      lim_y = 25'({h_m1, 8'h00});

      if (sx[24]) begin
         cx = '0;
      end else if (sx > top_x) begin
         cx = top_x;
      end else begin
         cx = sx;
      end
      if (sy[24]) begin
         cy = '0;
      end else if (sy > top_y) begin
         cy = top_y;
      end else begin
         cy = sy;
      end

      x0 = cx[8 +: XW];
      y0 = cy[8 +: YW];
      smp.in_image = !sx[24] && !sy[24] && (sx < lim_x) && (sy < lim_y);
      smp.x_odd    = x0[0];
      smp.y_odd    = y0[0];
      smp.fx       = cx[7:0];
      smp.fy       = cy[7:0];

      // corner at x0 and x0+1: one even and one odd column, likewise rows
      x_half      = x0 >> 1;
      y_half      = y0 >> 1;
      x_half_even = x_half + XW'(x0[0]);
      y_half_even = y_half + YW'(y0[0]);
      row_base[0] = AW'(y_half_even) * AW'(HALF_W);
      row_base[1] = AW'(y_half) * AW'(HALF_W);
      col_off[0]  = AW'(x_half_even);
      col_off[1]  = AW'(x_half);
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = row_base[b / 2] + col_off[b % 2];
      end

      // pixel write into bank {row parity, column parity}
      in_store = (16'(req.write_col) < 16'(MAX_WIDTH)) &&
                 (16'(req.write_row) < 16'(MAX_HEIGHT));
      wx       = XW'(req.write_col);
      wy       = YW'(req.write_row);
      wr_addr  = AW'(wy >> 1) * AW'(HALF_W) + AW'(wx >> 1);
      wr_en    = '0;
      if (item_valid && (req.op == brs_pkg::OP_WRITE) && in_store) begin
         wr_en[{wy[0], wx[0]}] = 1'b1;
      end
   end

endmodule

// ----- design/brs_interp.sv -----
// Bilinear weighting of the four neighbors and nodata alpha decision.
`timescale 1ns / 1ps

module brs_interp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      smp_valid,
   input  brs_pkg::smp_type          smp,
   input  brs_pkg::pixel_type [3:0]  bank_data,
   input  brs_pkg::nodata_type       nodata,
   output logic                      rsp_valid,
   output brs_pkg::rsp_type          rsp_data
);

   logic [2:0][7:0]  v00, v10, v01, v11;
   logic [8:0]       wx0, wx1, wy0, wy1;
   logic [2:0][15:0] top_in, bot_in;
   logic [2:0][15:0] top_ff, bot_ff;
   logic [7:0]       fy_ff;
   logic             inside_a_ff, inside_b_ff;
   logic             valid_a_ff, valid_b_ff, rsp_valid_ff;
   logic [2:0][7:0]  ch_in, ch_ff;
   logic [24:0]      vsum;
   logic             is_nodata;
   brs_pkg::rsp_type rsp_data_ff;

   // stage A: horizontal blend of the top and bottom rows
   always_comb begin
      v00 = bank_data[{smp.y_odd, smp.x_odd}];
      v10 = bank_data[{smp.y_odd, !smp.x_odd}];
      v01 = bank_data[{!smp.y_odd, smp.x_odd}];
      v11 = bank_data[{!smp.y_odd, !smp.x_odd}];
      wx1 = {1'b0, smp.fx};
      wx0 = 9'd256 - wx1;
      for (int c = 0; c < 3; c++) begin
         top_in[c] = 16'(17'(v00[c]) * 17'(wx0) + 17'(v10[c]) * 17'(wx1));
         bot_in[c] = 16'(17'(v01[c]) * 17'(wx0) + 17'(v11[c]) * 17'(wx1));
      end
   end

   // stage B: vertical blend, Q16 truncated
   always_comb begin
      wy1 = {1'b0, fy_ff};
      wy0 = 9'd256 - wy1;
      vsum = '0;
      for (int c = 0; c < 3; c++) begin
         vsum     = 25'(top_ff[c]) * 25'(wy0) + 25'(bot_ff[c]) * 25'(wy1);
         ch_in[c] = vsum[23:16];
      end
   end

   assign is_nodata = nodata.enable && (ch_ff[2] == nodata.red) &&
                      (ch_ff[1] == nodata.green) && (ch_ff[0] == nodata.blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= smp_valid;
         valid_b_ff   <= valid_a_ff;
         rsp_valid_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      fy_ff       <= smp.fy;
      inside_a_ff <= smp.in_image;
      ch_ff       <= ch_in;
      inside_b_ff <= inside_a_ff;
      rsp_data_ff.out_red   <= ch_ff[2];
      rsp_data_ff.out_green <= ch_ff[1];
      rsp_data_ff.out_blue  <= ch_ff[0];
      rsp_data_ff.out_alpha <= (inside_b_ff && !is_nodata) ?
                               brs_pkg::ALPHA_OPAQUE : brs_pkg::ALPHA_CLEAR;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- design/bilinear_rgb_sampler_nodata.sv -----
// Top level of the bilinear RGB sampler: request staging, pixel banks, config.
// A sample request passes the s1, s2 and bank-read, interp stage A, stage B and response registers before rsp_valid.
// Throughput: one request (write or sample) per cycle; busy is never raised.
// Pixels live in four banks split by row and column parity, so the four
// neighbors of a sample are read in the same cycle, one read port per bank.
// Reset clears pipeline control and config registers; the pixel memory is not cleared.
`timescale 1ns / 1ps

module bilinear_rgb_sampler_nodata #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  brs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output brs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [brs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic                         s1_valid_ff;
   brs_pkg::req_type             s1_req_ff;
   logic                         s2_valid_ff;
   brs_pkg::smp_type             s2_smp_ff;
   brs_pkg::smp_type             smp;
   logic [3:0]                   wr_en;
   logic [AW-1:0]                wr_addr;
   logic [3:0][AW-1:0]           rd_addr;
   brs_pkg::pixel_type           wr_pixel;
   brs_pkg::pixel_type [3:0]     bank_data;
   logic [9:0]                   width_ff, height_ff;
   brs_pkg::nodata_type          nodata_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= brs_pkg::SIZE_RESET;
         height_ff <= brs_pkg::SIZE_RESET;
         nodata_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brs_pkg::CSR_IMAGE_WIDTH:   width_ff         <= csr_data;
            brs_pkg::CSR_IMAGE_HEIGHT:  height_ff        <= csr_data;
            brs_pkg::CSR_NODATA_ENABLE: nodata_ff.enable <= csr_data[0];
            brs_pkg::CSR_NODATA_RED:    nodata_ff.red    <= csr_data[7:0];
            brs_pkg::CSR_NODATA_GREEN:  nodata_ff.green  <= csr_data[7:0];
            brs_pkg::CSR_NODATA_BLUE:   nodata_ff.blue   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // writes and samples go through the same stage, so bank accesses stay in order
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff && (s1_req_ff.op == brs_pkg::OP_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= req_data;
      s2_smp_ff <= smp;
   end

   brs_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr (
      .item_valid   (s1_valid_ff),
      .req          (s1_req_ff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .smp          (smp)
   );

   assign wr_pixel = '{red:   s1_req_ff.write_red,
                       green: s1_req_ff.write_green,
                       blue:  s1_req_ff.write_blue};

   for (genvar b = 0; b < 4; b++) begin : g_bank
      brs_ram #(
         .WIDTH ($bits(brs_pkg::pixel_type)),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr),
         .wr_data (wr_pixel),
         .rd_addr (rd_addr[b]),
         .rd_data (bank_data[b])
      );
   end

   brs_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .smp_valid (s2_valid_ff),
      .smp       (s2_smp_ff),
      .bank_data (bank_data),
      .nodata    (nodata_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
